// ===== rtl/core/ncs_pkg.sv =====
package ncs_pkg;

  localparam int COORD_W = 6;
  localparam int SLOT_W  = 6;
  localparam int DIST_W  = 9;
  localparam int IN_AXES = 8;

  localparam int ENT_CFG_W  = 7;
  localparam int AXES_CFG_W = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [ENT_CFG_W-1:0]  ENTRIES_RESET = 7'd64;
  localparam logic [AXES_CFG_W-1:0] AXES_RESET    = 4'd6;

  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXES    = 2'd1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/core/nearest_config_snap.sv =====
// Nearest stored coordinate search over a table of MAX_ENTRIES slots.
// Input channel (in_valid/in_ready): one request per item. operation OP_WRITE
// stores coord_0..coord_{MAX_AXES-1} into slot entry_index and
// gives no result; a slot at or above MAX_ENTRIES is dropped. OP_QUERY scans
// the first entries_in_use slots and returns one result on the output channel
// (out_valid/out_ready): the last exact match, else the first slot with the
// least L1 distance over the first axes_in_use axes.
// A query scans entries_in_use clipped to MAX_ENTRIES slots, then flushes and
// emits; a single distance unit reads one slot per cycle from the table memory
// through a read register and a distance register. With zero entries the query
// goes from accept straight to the emit state. in_ready is low while a query is
// in progress; a write leaves the block idle and ready.
// The result register holds until taken; a finished query waits for it, and a
// new request is taken while an older result is still pending.
// Configuration (cfg_valid/cfg_ready) is always ready: index 0 entries_in_use,
// index 1 axes_in_use. Reset sets them to 64 and 6 and clears control state;
// the table is undefined until written.
module nearest_config_snap #(
  parameter int MAX_ENTRIES = 64,
  parameter int MAX_AXES    = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ncs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ncs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         operation,
  input  logic [ncs_pkg::SLOT_W-1:0]   entry_index,
  input  logic [ncs_pkg::COORD_W-1:0]  coord_0,
  input  logic [ncs_pkg::COORD_W-1:0]  coord_1,
  input  logic [ncs_pkg::COORD_W-1:0]  coord_2,
  input  logic [ncs_pkg::COORD_W-1:0]  coord_3,
  input  logic [ncs_pkg::COORD_W-1:0]  coord_4,
  input  logic [ncs_pkg::COORD_W-1:0]  coord_5,
  input  logic [ncs_pkg::COORD_W-1:0]  coord_6,
  input  logic [ncs_pkg::COORD_W-1:0]  coord_7,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ncs_pkg::SLOT_W-1:0]   match_index,
  output logic                         exact_hit,
  output logic [ncs_pkg::DIST_W-1:0]   distance
);
  import ncs_pkg::*;

  localparam int AW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int WIDE_W = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int ROW_W  = MAX_AXES * COORD_W;

  state_t state, state_next;

  logic [ENT_CFG_W-1:0]  entries_in_use;
  logic [AXES_CFG_W-1:0] axes_in_use;

  logic [ROW_W-1:0] mem [MAX_ENTRIES];
  logic [ROW_W-1:0] rdata;

  logic [COORD_W-1:0] in_coord [IN_AXES];
  logic [ROW_W-1:0]   in_row;
  logic [ROW_W-1:0]   query;

  logic [CNT_W-1:0] n_sat;
  logic [CNT_W-1:0] n_ent;
  logic [CNT_W-1:0] rd_cnt;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic [WIDE_W-1:0] wide_idx;
  logic             wr_in_range;

  logic             s1_valid;
  logic [AW-1:0]    s1_slot;
  logic             s2_valid;
  logic [AW-1:0]    s2_slot;
  logic [DIST_W-1:0] s2_dist;
  logic [DIST_W-1:0] dist_next;

  logic             have_best;
  logic [AW-1:0]    best_slot;
  logic [DIST_W-1:0] least_sum;
  logic             have_exact;
  logic [AW-1:0]    exact_slot;

  logic in_acc;
  logic query_acc;
  logic write_acc;
  logic issue;
  logic last_issue;
  logic emit;
  logic [WIDE_W-1:0] res_slot;

  assign cfg_ready = 1'b1;

  assign in_coord[0] = coord_0;
  assign in_coord[1] = coord_1;
  assign in_coord[2] = coord_2;
  assign in_coord[3] = coord_3;
  assign in_coord[4] = coord_4;
  assign in_coord[5] = coord_5;
  assign in_coord[6] = coord_6;
  assign in_coord[7] = coord_7;

  always_comb begin
    for (int a = 0; a < MAX_AXES; a++) begin
      in_row[a*COORD_W +: COORD_W] = in_coord[a];
    end
  end

  assign in_acc    = in_valid && in_ready;
  assign query_acc = in_acc && (operation == OP_QUERY);
  assign write_acc = in_acc && (operation == OP_WRITE);

  assign n_sat = (32'(entries_in_use) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                      : CNT_W'(entries_in_use);

  assign wide_idx    = WIDE_W'(entry_index);
  assign wr_addr     = wide_idx[AW-1:0];
  assign wr_in_range = 32'(entry_index) < MAX_ENTRIES;

  assign rd_addr    = rd_cnt[AW-1:0];
  assign last_issue = rd_cnt == (n_ent - CNT_W'(1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (query_acc) begin
          state_next = (n_sat == '0) ? ST_EMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_issue) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!s1_valid && !s2_valid) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    emit     = 1'b0;
    case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_SCAN:  issue = 1'b1;
      ST_FLUSH: ;
      ST_EMIT:  emit = !out_valid || out_ready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      entries_in_use <= ENTRIES_RESET;
      axes_in_use    <= AXES_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENTRIES: entries_in_use <= cfg_data[ENT_CFG_W-1:0];
          REG_AXES:    axes_in_use    <= cfg_data[AXES_CFG_W-1:0];
          default:     ;
        endcase
      end
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (write_acc && wr_in_range) begin
      mem[wr_addr] <= in_row;
    end
    if (issue) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (query_acc) begin
      query  <= in_row;
      n_ent  <= n_sat;
      rd_cnt <= '0;
    end else if (issue) begin
      rd_cnt <= rd_cnt + CNT_W'(1);
    end
    s1_slot <= rd_addr;
    s2_slot <= s1_slot;
    s2_dist <= dist_next;
  end

  // shared distance unit
  always_comb begin
    logic [COORD_W-1:0] qa;
    logic [COORD_W-1:0] ta;
    logic [COORD_W-1:0] diff;
    dist_next = '0;
    for (int a = 0; a < MAX_AXES; a++) begin
      qa   = query[a*COORD_W +: COORD_W];
      ta   = rdata[a*COORD_W +: COORD_W];
      diff = (qa > ta) ? (qa - ta) : (ta - qa);
      if (32'(axes_in_use) > a) begin
        dist_next = dist_next + DIST_W'(diff);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best  <= 1'b0;
      have_exact <= 1'b0;
    end else if (query_acc) begin
      have_best  <= 1'b0;
      have_exact <= 1'b0;
    end else if (s2_valid) begin
      if (!have_best || (s2_dist < least_sum)) begin
        have_best <= 1'b1;
      end
      if (s2_dist == '0) begin
        have_exact <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query_acc) begin
      best_slot  <= '0;
      least_sum  <= '0;
      exact_slot <= '0;
    end else if (s2_valid) begin
      if (!have_best || (s2_dist < least_sum)) begin
        best_slot <= s2_slot;
        least_sum <= s2_dist;
      end
      if (s2_dist == '0) begin
        exact_slot <= s2_slot;
      end
    end
  end

  assign res_slot = have_exact ? WIDE_W'(exact_slot) : WIDE_W'(best_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      match_index <= res_slot[SLOT_W-1:0];
      exact_hit   <= have_exact;
      distance    <= have_exact ? '0 : least_sum;
    end
  end

  a_exact_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!exact_hit || distance == '0))
    else $error("exact hit with nonzero distance");

  a_scan_window: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (state == ST_SCAN || state == ST_FLUSH))
    else $error("distance result outside a scan");

  a_query_start: assert property (@(posedge clk) disable iff (rst)
    (query_acc && entries_in_use != '0) |=> state == ST_SCAN)
    else $error("query with entries did not start a scan");

  a_best_monotonic: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && have_best) |=> least_sum <= $past(least_sum))
    else $error("best distance grew during a scan");

endmodule
